FILE: rtl/core/mffk_pkg.sv
// shared constants and types for the max flow block
// no dependencies
package mffk_pkg;
  localparam int MaxVertices = 16;
  localparam int FracBits = 8;
  localparam int ValW = 28;
  localparam int CapW = 24;
  localparam int VtxW = 4;
  localparam int CntW = 5;
  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_RUN = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic [1:0] CFG_COUNT = 2'd0;
  localparam logic [1:0] CFG_SOURCE = 2'd1;
  localparam logic [1:0] CFG_SINK = 2'd2;
  localparam logic KIND_FLOW = 1'b0;
  localparam logic KIND_ENTRY = 1'b1;

  typedef struct packed {
    logic [1:0] req_type;
    logic [VtxW-1:0] from_vertex;
    logic [VtxW-1:0] to_vertex;
    logic [CapW-1:0] capacity;
  } req_t;

  typedef struct packed {
    logic result_kind;
    logic [ValW-1:0] result_value;
  } res_t;
endpackage

FILE: rtl/core/mffk_if.sv
// valid/ready channel carrying one payload item
// no dependencies; the payload type is a parameter
interface mffk_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/core/max_flow_ford_fulkerson.sv
// max flow block: residual ram, clear sweep and search/augment sequencer
// depends on mffk_pkg, mffk_if, mffk_ram
// Write and read items each access the ram once; a run item repeats, per augmenting path,
// a depth-first search that reads the residual entries one at a time through the
// single ram port, then a bottleneck and update walk along the path edges, and ends with
// one more final search. After reset a clearing pass writes all MaxVertices*MaxVertices
// entries before the first item is accepted. The result waits in an output register.
module max_flow_ford_fulkerson (
  input  logic clk,
  input  logic rst_n,
  mffk_if.sink in_ch,
  mffk_if.source out_ch,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [mffk_pkg::CntW-1:0] cfg_data
);
  localparam int MAX_VERTICES = mffk_pkg::MaxVertices;
  localparam int VW = mffk_pkg::VtxW;
  localparam int AW = 2 * VW;
  localparam int Depth = MAX_VERTICES * MAX_VERTICES;
  localparam int VL = mffk_pkg::ValW;
  localparam logic [VL-1:0] Sat = {VL{1'b1}};
  localparam logic [VL:0] IntMax = (VL+1)'(32'h7fffffff);

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_WR, S_RD, S_RD2, S_RUN, S_POP, S_SCAN, S_SCANW, S_SCAN2,
    S_CHK, S_BN, S_BNW, S_BN2, S_UPF, S_UPFW, S_UPF2, S_UPB, S_UPBW, S_UPB2,
    S_TOT, S_OUT
  } state_t;

  state_t st_r;
  logic [4:0] vcnt_r;
  logic [VW-1:0] src_r, snk_r;
  logic [AW:0] clr_r;
  mffk_pkg::req_t req_r;
  logic [MAX_VERTICES-1:0] vis_r;
  logic [VW-1:0] par_r [MAX_VERTICES];
  logic [VW-1:0] stk_r [MAX_VERTICES];
  logic [VW:0] sp_r;
  logic [VW-1:0] u_r, v_r;
  logic [VW:0] n_r;
  logic [VL:0] bn_r;
  logic [VL-1:0] tot_r;
  logic ovalid_r;
  mffk_pkg::res_t ores_r;

  logic we;
  logic [AW-1:0] addr;
  logic [VL-1:0] wdata, rdata;
  logic [VL:0] bsum;

  mffk_ram #(.Width(VL), .Depth(Depth)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  assign in_ch.ready = (st_r == S_IDLE) && !ovalid_r;
  assign out_ch.valid = ovalid_r;
  assign out_ch.payload = ores_r;
  assign bsum = {1'b0, rdata} + bn_r;

  always_comb begin
    we = 1'b0;
    addr = '0;
    wdata = '0;
    case (st_r)
      S_CLR: begin
        we = 1'b1;
        addr = clr_r[AW-1:0];
      end
      S_WR: begin
        we = 1'b1;
        addr = {req_r.from_vertex, req_r.to_vertex};
        wdata = VL'(req_r.capacity);
      end
      S_RD: addr = {req_r.from_vertex, req_r.to_vertex};
      S_SCAN, S_SCANW: addr = {u_r, v_r};
      S_BN, S_BNW: addr = {par_r[v_r], v_r};
      S_UPF, S_UPFW: addr = {par_r[v_r], v_r};
      S_UPF2: begin
        we = 1'b1;
        addr = {par_r[v_r], v_r};
        wdata = rdata - bn_r[VL-1:0];
      end
      S_UPB, S_UPBW: addr = {v_r, par_r[v_r]};
      S_UPB2: begin
        we = 1'b1;
        addr = {v_r, par_r[v_r]};
        wdata = bsum[VL] ? Sat : bsum[VL-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR;
      clr_r <= '0;
      vcnt_r <= 5'd16;
      src_r <= '0;
      snk_r <= VW'(15);
      ovalid_r <= 1'b0;
      vis_r <= '0;
      sp_r <= '0;
      tot_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          mffk_pkg::CFG_COUNT: vcnt_r <= cfg_data;
          mffk_pkg::CFG_SOURCE: src_r <= cfg_data[VW-1:0];
          mffk_pkg::CFG_SINK: snk_r <= cfg_data[VW-1:0];
          default: ;
        endcase
      end
      if (ovalid_r && out_ch.ready) begin
        ovalid_r <= 1'b0;
      end
      case (st_r)
        S_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == (AW+1)'(Depth - 1)) begin
            st_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_ch.valid && !ovalid_r) begin
            req_r <= in_ch.payload;
            case (in_ch.payload.req_type)
              mffk_pkg::REQ_WRITE: st_r <= S_WR;
              mffk_pkg::REQ_RUN: st_r <= S_RUN;
              mffk_pkg::REQ_READ: st_r <= S_RD;
              default: ;
            endcase
          end
        end
        S_WR: st_r <= S_IDLE;
        S_RD: st_r <= S_RD2;
        S_RD2: begin
          ores_r.result_kind <= mffk_pkg::KIND_ENTRY;
          ores_r.result_value <= rdata;
          st_r <= S_OUT;
        end
        S_RUN: begin
          tot_r <= '0;
          n_r <= (vcnt_r > 5'(MAX_VERTICES)) ? (VW+1)'(MAX_VERTICES) : (VW+1)'(vcnt_r);
          if ((VW+1)'(src_r) >= ((vcnt_r > 5'(MAX_VERTICES)) ? (VW+1)'(MAX_VERTICES)
               : (VW+1)'(vcnt_r)) || (VW+1)'(snk_r) >= ((vcnt_r > 5'(MAX_VERTICES))
               ? (VW+1)'(MAX_VERTICES) : (VW+1)'(vcnt_r)) || src_r == snk_r) begin
            ores_r.result_kind <= mffk_pkg::KIND_FLOW;
            ores_r.result_value <= '0;
            st_r <= S_OUT;
          end else begin
            vis_r <= MAX_VERTICES'(1) << src_r;
            stk_r[0] <= src_r;
            sp_r <= (VW+1)'(1);
            st_r <= S_POP;
          end
        end
        S_POP: begin
          if (sp_r == '0) begin
            st_r <= S_CHK;
          end else begin
            u_r <= stk_r[sp_r[VW-1:0] - 1'b1];
            sp_r <= sp_r - 1'b1;
            v_r <= '0;
            st_r <= S_SCAN;
          end
        end
        S_SCAN: st_r <= S_SCANW;
        S_SCANW: st_r <= S_SCAN2;
        S_SCAN2: begin
          if (!vis_r[v_r] && rdata != '0) begin
            if (sp_r < (VW+1)'(MAX_VERTICES)) begin
              stk_r[sp_r[VW-1:0]] <= v_r;
              sp_r <= sp_r + 1'b1;
            end
            par_r[v_r] <= u_r;
            vis_r[v_r] <= 1'b1;
          end
          if ((VW+1)'(v_r) + 1'b1 >= n_r) begin
            st_r <= S_POP;
          end else begin
            v_r <= v_r + 1'b1;
            st_r <= S_SCAN;
          end
        end
        S_CHK: begin
          if (vis_r[snk_r]) begin
            bn_r <= IntMax;
            v_r <= snk_r;
            st_r <= S_BN;
          end else begin
            ores_r.result_kind <= mffk_pkg::KIND_FLOW;
            ores_r.result_value <= VL'(tot_r >> mffk_pkg::FracBits);
            st_r <= S_OUT;
          end
        end
        S_BN: st_r <= S_BNW;
        S_BNW: st_r <= S_BN2;
        S_BN2: begin
          if ({1'b0, rdata} < bn_r) begin
            bn_r <= {1'b0, rdata};
          end
          if (par_r[v_r] == src_r) begin
            v_r <= snk_r;
            st_r <= S_UPF;
          end else begin
            v_r <= par_r[v_r];
            st_r <= S_BN;
          end
        end
        S_UPF: st_r <= S_UPFW;
        S_UPFW: st_r <= S_UPF2;
        S_UPF2: st_r <= S_UPB;
        S_UPB: st_r <= S_UPBW;
        S_UPBW: st_r <= S_UPB2;
        S_UPB2: begin
          if (par_r[v_r] == src_r) begin
            st_r <= S_TOT;
          end else begin
            v_r <= par_r[v_r];
            st_r <= S_UPF;
          end
        end
        S_TOT: begin
          tot_r <= (({1'b0, tot_r} + bn_r) > {1'b0, Sat}) ? Sat
                   : VL'({1'b0, tot_r} + bn_r);
          vis_r <= MAX_VERTICES'(1) << src_r;
          stk_r[0] <= src_r;
          sp_r <= (VW+1)'(1);
          st_r <= S_POP;
        end
        S_OUT: begin
          ovalid_r <= 1'b1;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: rtl/core/mffk_ram.sv
// generic single port ram with registered read
// no dependencies
module mffk_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0] wdata,
  output logic [Width-1:0] rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

FILE: dv/max_flow_ford_fulkerson_test.sv
// self-checking testbench for the max flow block: capacity writes, flow runs, residual reads
// depends on mffk_pkg, mffk_if and max_flow_ford_fulkerson from the rtl
module max_flow_ford_fulkerson_test;
  localparam int CycleLimit = 20000000;
  localparam int DrainCycles = 64;
  localparam int IdleCycles = 12;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [mffk_pkg::CntW-1:0] cfg_data;

  mffk_if #(.T(mffk_pkg::req_t)) in_if ();
  mffk_if #(.T(mffk_pkg::res_t)) out_if ();

  max_flow_ford_fulkerson i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_if),
    .out_ch(out_if),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // shadow of the block state
  logic [mffk_pkg::ValW-1:0] resid [mffk_pkg::MaxVertices][mffk_pkg::MaxVertices];
  int unsigned vtx_count;
  int unsigned src_vtx;
  int unsigned snk_vtx;

  mffk_pkg::res_t result_q [$];
  int mismatches = 0;
  int burst_left;
  int cycle_cnt = 0;
  int stall_mode = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver stall pattern
  always @(negedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_if.ready <= 1'b1;
      1: out_if.ready <= ($urandom_range(0, 3) != 0);
      2: out_if.ready <= ($urandom_range(0, 3) == 0);
      default: out_if.ready <= (cycle_cnt[3:0] < 4'd10);
    endcase
  end

  // result checker
  always @(posedge clk) begin
    mffk_pkg::res_t exp_res;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (result_q.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10)
          $display("unexpected result kind %0d value %0h", out_if.payload.result_kind,
                   out_if.payload.result_value);
      end else begin
        exp_res = result_q.pop_front();
        if (exp_res.result_kind !== out_if.payload.result_kind ||
            exp_res.result_value !== out_if.payload.result_value) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch: expected kind %0d value %0h, got kind %0d value %0h",
                     exp_res.result_kind, exp_res.result_value,
                     out_if.payload.result_kind, out_if.payload.result_value);
        end
      end
    end
  end

  function automatic logic [mffk_pkg::ValW-1:0] compute_max_flow();
    int unsigned n;
    int unsigned u;
    int unsigned v;
    int depth;
    bit [mffk_pkg::MaxVertices-1:0] seen;
    int unsigned parent [mffk_pkg::MaxVertices];
    int unsigned stack [mffk_pkg::MaxVertices];
    longint unsigned bneck;
    longint unsigned sum;
    logic [mffk_pkg::ValW-1:0] total;
    n = (vtx_count > mffk_pkg::MaxVertices) ? mffk_pkg::MaxVertices : vtx_count;
    total = '0;
    if (src_vtx >= n || snk_vtx >= n || src_vtx == snk_vtx) return '0;
    forever begin
      seen = '0;
      depth = 0;
      stack[depth++] = src_vtx;
      seen[src_vtx] = 1'b1;
      while (depth > 0) begin
        u = stack[--depth];
        for (v = 0; v < n; v++) begin
          if (!seen[v] && resid[u][v] != 0) begin
            if (depth < mffk_pkg::MaxVertices) stack[depth++] = v;
            parent[v] = u;
            seen[v] = 1'b1;
          end
        end
      end
      if (!seen[snk_vtx]) break;
      bneck = 64'd2147483647;
      for (v = snk_vtx; v != src_vtx; v = parent[v])
        if (resid[parent[v]][v] < bneck) bneck = resid[parent[v]][v];
      for (v = snk_vtx; v != src_vtx; v = parent[v]) begin
        u = parent[v];
        resid[u][v] = resid[u][v] - bneck[mffk_pkg::ValW-1:0];
        sum = resid[v][u] + bneck;
        resid[v][u] = (sum > 64'h0FFFFFFF) ? '1 : sum[mffk_pkg::ValW-1:0];
      end
      sum = total + bneck;
      total = (sum > 64'h0FFFFFFF) ? '1 : sum[mffk_pkg::ValW-1:0];
    end
    return total >> mffk_pkg::FracBits;
  endfunction

  task automatic predict_item(input mffk_pkg::req_t req);
    mffk_pkg::res_t r;
    case (req.req_type)
      mffk_pkg::REQ_WRITE: resid[req.from_vertex][req.to_vertex] = {4'd0, req.capacity};
      mffk_pkg::REQ_RUN: begin
        r.result_kind = mffk_pkg::KIND_FLOW;
        r.result_value = compute_max_flow();
        result_q = {result_q, r};
      end
      mffk_pkg::REQ_READ: begin
        r.result_kind = mffk_pkg::KIND_ENTRY;
        r.result_value = resid[req.from_vertex][req.to_vertex];
        result_q = {result_q, r};
      end
      default: ;
    endcase
  endtask

  task automatic send_item(input logic [1:0] kind, input int unsigned row,
                           input int unsigned col, input int unsigned cap);
    mffk_pkg::req_t req;
    int gap;
    req.req_type = kind;
    req.from_vertex = row[mffk_pkg::VtxW-1:0];
    req.to_vertex = col[mffk_pkg::VtxW-1:0];
    req.capacity = cap[mffk_pkg::CapW-1:0];
    if (burst_left <= 0) begin
      gap = $urandom_range(1, 6);
      @(negedge clk);
      in_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    @(negedge clk);
    in_if.valid <= 1'b1;
    in_if.payload <= req;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    predict_item(req);
    burst_left--;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_if.valid <= 1'b0;
    burst_left = 0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (IdleCycles) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [1:0] idx, input int unsigned val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[mffk_pkg::CntW-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      mffk_pkg::CFG_COUNT: vtx_count = val & 5'h1f;
      mffk_pkg::CFG_SOURCE: src_vtx = val & 4'hf;
      mffk_pkg::CFG_SINK: snk_vtx = val & 4'hf;
      default: ;
    endcase
  endtask

  task automatic set_graph_cfg(input int unsigned n, input int unsigned s, input int unsigned t);
    wait_idle();
    write_cfg(mffk_pkg::CFG_COUNT, n);
    write_cfg(mffk_pkg::CFG_SOURCE, s);
    write_cfg(mffk_pkg::CFG_SINK, t);
  endtask

  task automatic clear_rows(input int unsigned n);
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++)
        if (resid[i][j] != 0) send_item(mffk_pkg::REQ_WRITE, i, j, 0);
  endtask

  task automatic test_access_extremes();
    send_item(mffk_pkg::REQ_WRITE, 0, 15, 24'hffffff);
    send_item(mffk_pkg::REQ_WRITE, 15, 0, 24'h000001);
    send_item(mffk_pkg::REQ_WRITE, 9, 6, 24'h5a5a5a);
    send_item(mffk_pkg::REQ_READ, 0, 15, 0);
    send_item(mffk_pkg::REQ_READ, 15, 0, 24'hffffff);
    send_item(mffk_pkg::REQ_READ, 9, 6, 0);
    send_item(mffk_pkg::REQ_READ, 3, 3, 0);
    send_item(mffk_pkg::REQ_UNUSED, 5, 5, 24'h123456);
    send_item(mffk_pkg::REQ_READ, 5, 5, 0);
  endtask

  task automatic test_flow_directed();
    // default config: single direct edge at full scale
    send_item(mffk_pkg::REQ_RUN, 0, 0, 0);
    send_item(mffk_pkg::REQ_READ, 15, 0, 0);
    send_item(mffk_pkg::REQ_READ, 0, 15, 0);
    // wide parallel fan through every middle vertex at max capacity
    for (int i = 1; i < 15; i++) begin
      send_item(mffk_pkg::REQ_WRITE, 0, i, 24'hffffff);
      send_item(mffk_pkg::REQ_WRITE, i, 15, 24'hffffff);
    end
    send_item(mffk_pkg::REQ_RUN, 0, 0, 0);
    send_item(mffk_pkg::REQ_READ, 15, 7, 0);
  endtask

  task automatic test_cfg_corners();
    set_graph_cfg(31, 0, 15);
    send_item(mffk_pkg::REQ_RUN, 0, 0, 0);
    set_graph_cfg(2, 0, 1);
    send_item(mffk_pkg::REQ_WRITE, 0, 1, 24'h0000ff);
    send_item(mffk_pkg::REQ_RUN, 0, 0, 0);
    set_graph_cfg(4, 2, 2);
    send_item(mffk_pkg::REQ_RUN, 0, 0, 0);
    set_graph_cfg(4, 5, 1);
    send_item(mffk_pkg::REQ_RUN, 0, 0, 0);
    set_graph_cfg(4, 0, 9);
    send_item(mffk_pkg::REQ_RUN, 0, 0, 0);
    set_graph_cfg(16, 15, 0);
    send_item(mffk_pkg::REQ_RUN, 0, 0, 0);
    set_graph_cfg(16, 0, 15);
    clear_rows(mffk_pkg::MaxVertices);
    wait_idle();
  endtask

  task automatic test_random_graphs();
    int unsigned n;
    int unsigned s;
    int unsigned t;
    int unsigned cap;
    int sent;
    int edges;
    sent = 0;
    while (sent < 500) begin
      n = ($urandom_range(0, 7) == 0) ? 16 : $urandom_range(2, 8);
      if ($urandom_range(0, 9) == 0) n = $urandom_range(17, 31);
      s = $urandom_range(0, 15);
      t = $urandom_range(0, 15);
      if ($urandom_range(0, 4) != 0) begin
        s = $urandom_range(0, (n > 16 ? 16 : n) - 1);
        t = $urandom_range(0, (n > 16 ? 16 : n) - 1);
      end
      set_graph_cfg(n, s, t);
      if (n > 16) n = 16;
      edges = (n <= 8) ? $urandom_range(n, 3 * n) : $urandom_range(8, 24);
      for (int e = 0; e < edges; e++) begin
        case ($urandom_range(0, 3))
          0: cap = $urandom;
          1: cap = $urandom_range(0, 255);
          2: cap = $urandom_range(0, 65535);
          default: cap = 0;
        endcase
        if ($urandom_range(0, 9) == 0)
          send_item(mffk_pkg::REQ_WRITE, $urandom_range(0, 15), $urandom_range(0, 15), cap);
        else
          send_item(mffk_pkg::REQ_WRITE, $urandom_range(0, n - 1), $urandom_range(0, n - 1),
                    cap);
        sent++;
      end
      if ($urandom_range(0, 9) == 0) begin
        send_item(mffk_pkg::REQ_UNUSED, $urandom_range(0, 15), $urandom_range(0, 15),
                  $urandom);
        sent++;
      end
      send_item(mffk_pkg::REQ_RUN, $urandom_range(0, 15), $urandom_range(0, 15), $urandom);
      sent++;
      repeat ($urandom_range(1, 5)) begin
        send_item(mffk_pkg::REQ_READ, $urandom_range(0, 15), $urandom_range(0, 15),
                  $urandom);
        sent++;
      end
      if ($urandom_range(0, 2) == 0) begin
        send_item(mffk_pkg::REQ_RUN, 0, 0, 0);
        sent++;
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = mffk_pkg::CFG_COUNT;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.payload = '0;
    burst_left = 0;
    vtx_count = 16;
    src_vtx = 0;
    snk_vtx = 15;
    for (int i = 0; i < mffk_pkg::MaxVertices; i++)
      for (int j = 0; j < mffk_pkg::MaxVertices; j++) resid[i][j] = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_access_extremes();
    test_flow_directed();
    test_cfg_corners();
    test_random_graphs();
    wait_idle();
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

FILE: files.f
rtl/core/mffk_pkg.sv
rtl/core/mffk_if.sv
rtl/core/mffk_ram.sv
rtl/core/max_flow_ford_fulkerson.sv
dv/max_flow_ford_fulkerson_test.sv
